/* design/mr3k_pkg.sv */
// ----------------------------------------------------------------------------
// mr3k_pkg
// Shared constants, opcodes and types for the MIPS I integer core.
// ----------------------------------------------------------------------------
package mr3k_pkg;

   localparam int NumRegsDefault = 32;

   typedef logic [31:0] word_type;

   localparam word_type RESET_PC = 32'hbfc00000;
   localparam word_type VEC_BOOT = 32'hbfc00180;
   localparam word_type VEC_NORM = 32'h80000080;

   // input item commands
   localparam logic [1:0] CMD_EXEC = 2'd0;
   localparam logic [1:0] CMD_LOAD = 2'd1;
   localparam logic [1:0] CMD_IRQ  = 2'd2;

   // bus request codes
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   // exception kinds as reported on the result channel
   localparam logic [3:0] EXC_NONE = 4'd0;
   localparam logic [3:0] EXC_IRQ  = 4'd1;
   localparam logic [3:0] EXC_ADEL = 4'd2;
   localparam logic [3:0] EXC_ADES = 4'd3;
   localparam logic [3:0] EXC_SYS  = 4'd4;
   localparam logic [3:0] EXC_BP   = 4'd5;
   localparam logic [3:0] EXC_RI   = 4'd6;
   localparam logic [3:0] EXC_CPU  = 4'd7;
   localparam logic [3:0] EXC_OV   = 4'd8;

   // cause register codes
   localparam logic [4:0] CAUSE_INT  = 5'd0;
   localparam logic [4:0] CAUSE_ADEL = 5'd4;
   localparam logic [4:0] CAUSE_ADES = 5'd5;
   localparam logic [4:0] CAUSE_SYS  = 5'd8;
   localparam logic [4:0] CAUSE_BP   = 5'd9;
   localparam logic [4:0] CAUSE_RI   = 5'd10;
   localparam logic [4:0] CAUSE_CPU  = 5'd11;
   localparam logic [4:0] CAUSE_OV   = 5'd12;

   // pending load kinds
   localparam logic [2:0] LK_NONE = 3'd0;
   localparam logic [2:0] LK_LB   = 3'd1;
   localparam logic [2:0] LK_LBU  = 3'd2;
   localparam logic [2:0] LK_LH   = 3'd3;
   localparam logic [2:0] LK_LHU  = 3'd4;
   localparam logic [2:0] LK_LW   = 3'd5;

   // configuration register indexes
   localparam logic [0:0] CSR_BOOT_VECTORS = 1'd0;
   localparam logic [0:0] CSR_IRQ_MASK     = 1'd1;

   // primary opcodes
   localparam logic [5:0] OP_SPECIAL   = 6'd0;
   localparam logic [5:0] OP_REGIMM    = 6'd1;
   localparam logic [5:0] OP_J         = 6'd2;
   localparam logic [5:0] OP_JAL       = 6'd3;
   localparam logic [5:0] OP_BEQ       = 6'd4;
   localparam logic [5:0] OP_BNE       = 6'd5;
   localparam logic [5:0] OP_BLEZ      = 6'd6;
   localparam logic [5:0] OP_BGTZ      = 6'd7;
   localparam logic [5:0] OP_ADDI      = 6'd8;
   localparam logic [5:0] OP_ADDI_WRAP = 6'd9;
   localparam logic [5:0] OP_SLTI      = 6'd10;
   localparam logic [5:0] OP_SLTI_UNS  = 6'd11;
   localparam logic [5:0] OP_ANDI      = 6'd12;
   localparam logic [5:0] OP_ORI       = 6'd13;
   localparam logic [5:0] OP_XORI      = 6'd14;
   localparam logic [5:0] OP_LUI       = 6'd15;
   localparam logic [5:0] OP_COP0      = 6'd16;
   localparam logic [5:0] OP_COP1      = 6'd17;
   localparam logic [5:0] OP_COP2      = 6'd18;
   localparam logic [5:0] OP_COP3      = 6'd19;
   localparam logic [5:0] OP_LB        = 6'd32;
   localparam logic [5:0] OP_LH        = 6'd33;
   localparam logic [5:0] OP_LWL       = 6'd34;
   localparam logic [5:0] OP_LW        = 6'd35;
   localparam logic [5:0] OP_LBU       = 6'd36;
   localparam logic [5:0] OP_LHU       = 6'd37;
   localparam logic [5:0] OP_LWR       = 6'd38;
   localparam logic [5:0] OP_SB        = 6'd40;
   localparam logic [5:0] OP_SH        = 6'd41;
   localparam logic [5:0] OP_SWL       = 6'd42;
   localparam logic [5:0] OP_SW        = 6'd43;
   localparam logic [5:0] OP_SWR       = 6'd46;
   localparam logic [5:0] OP_LWC0      = 6'd48;
   localparam logic [5:0] OP_LWC1      = 6'd49;
   localparam logic [5:0] OP_LWC2      = 6'd50;
   localparam logic [5:0] OP_LWC3      = 6'd51;
   localparam logic [5:0] OP_SWC0      = 6'd56;
   localparam logic [5:0] OP_SWC1      = 6'd57;
   localparam logic [5:0] OP_SWC2      = 6'd58;
   localparam logic [5:0] OP_SWC3      = 6'd59;

   // SPECIAL function codes
   localparam logic [5:0] FN_SLL     = 6'd0;
   localparam logic [5:0] FN_SRL     = 6'd2;
   localparam logic [5:0] FN_SRA     = 6'd3;
   localparam logic [5:0] FN_SLLV    = 6'd4;
   localparam logic [5:0] FN_SRLV    = 6'd6;
   localparam logic [5:0] FN_SRAV    = 6'd7;
   localparam logic [5:0] FN_JR      = 6'd8;
   localparam logic [5:0] FN_JALR    = 6'd9;
   localparam logic [5:0] FN_SYSCALL = 6'd12;
   localparam logic [5:0] FN_BREAK   = 6'd13;
   localparam logic [5:0] FN_MFHI    = 6'd16;
   localparam logic [5:0] FN_MTHI    = 6'd17;
   localparam logic [5:0] FN_MFLO    = 6'd18;
   localparam logic [5:0] FN_MTLO    = 6'd19;
   localparam logic [5:0] FN_MULT    = 6'd24;
   localparam logic [5:0] FN_MULTU   = 6'd25;
   localparam logic [5:0] FN_DIV     = 6'd26;
   localparam logic [5:0] FN_DIVU    = 6'd27;
   localparam logic [5:0] FN_ADD     = 6'd32;
   localparam logic [5:0] FN_ADDU    = 6'd33;
   localparam logic [5:0] FN_SUB     = 6'd34;
   localparam logic [5:0] FN_SUBU    = 6'd35;
   localparam logic [5:0] FN_AND     = 6'd36;
   localparam logic [5:0] FN_OR      = 6'd37;
   localparam logic [5:0] FN_XOR     = 6'd38;
   localparam logic [5:0] FN_NOR     = 6'd39;
   localparam logic [5:0] FN_SLT     = 6'd42;
   localparam logic [5:0] FN_SLTU    = 6'd43;

   // REGIMM rt codes
   localparam logic [4:0] RI_BLTZ   = 5'd0;
   localparam logic [4:0] RI_BGEZ   = 5'd1;
   localparam logic [4:0] RI_BLTZAL = 5'd16;
   localparam logic [4:0] RI_BGEZAL = 5'd17;

   // request to the multiply/divide unit
   typedef struct packed {
      logic start;
      logic is_div;
      logic is_signed;
   } md_req_type;

endpackage

/* design/mr3k_req_if.sv */
// ----------------------------------------------------------------------------
// mr3k_req_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface mr3k_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] instr_word;
   logic [31:0] load_data;
   logic        irq_line;

   modport source (output valid, cmd, instr_word, load_data, irq_line, input ready);
   modport sink   (input valid, cmd, instr_word, load_data, irq_line, output ready);
endinterface

/* design/mr3k_rsp_if.sv */
// ----------------------------------------------------------------------------
// mr3k_rsp_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface mr3k_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] fetch_addr;
   logic [1:0]  mem_req;
   logic [31:0] mem_addr;
   logic [2:0]  mem_size;
   logic [31:0] mem_wdata;
   logic [3:0]  exc_kind;

   modport source (output valid, fetch_addr, mem_req, mem_addr, mem_size, mem_wdata,
                   exc_kind, input ready);
   modport sink   (input valid, fetch_addr, mem_req, mem_addr, mem_size, mem_wdata,
                   exc_kind, output ready);
endinterface

/* design/mr3k_regfile.sv */
// ----------------------------------------------------------------------------
// mr3k_regfile
// General register file: synchronous two-read one-write memory, valid bits
// make unwritten entries read as zero after reset. Entry zero is never written.
// ----------------------------------------------------------------------------
module mr3k_regfile #(
   parameter int NUM_REGS = mr3k_pkg::NumRegsDefault,
   localparam int AW = $clog2(NUM_REGS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   output logic [31:0]   rd_data_a,
   output logic [31:0]   rd_data_b
);
   import mr3k_pkg::*;

   word_type            regs_ff [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   word_type            rdat_a_ff, rdat_b_ff;
   logic                rvld_a_ff, rvld_b_ff;
   logic                wr_ok;

   assign wr_ok = wr_en && (wr_addr != '0);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         regs_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdat_a_ff <= regs_ff[rd_addr_a];
         rdat_b_ff <= regs_ff[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvld_a_ff <= 1'b0;
         rvld_b_ff <= 1'b0;
      end else begin
         if (wr_ok) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvld_a_ff <= valid_ff[rd_addr_a];
            rvld_b_ff <= valid_ff[rd_addr_b];
         end
      end
   end

   assign rd_data_a = rvld_a_ff ? rdat_a_ff : '0;
   assign rd_data_b = rvld_b_ff ? rdat_b_ff : '0;

endmodule

/* design/mr3k_muldiv.sv */
// ----------------------------------------------------------------------------
// mr3k_muldiv
// Multiply/divide unit: 32x32 multiply with signed correction (MD_MUL, then MD_MFIX),
// restoring divide one quotient bit per cycle (MD_DIV, then MD_DFIX).
// ----------------------------------------------------------------------------
module mr3k_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  mr3k_pkg::md_req_type md_req,
   input  mr3k_pkg::word_type   opa,
   input  mr3k_pkg::word_type   opb,
   output logic                 done,
   output mr3k_pkg::word_type   hi,
   output mr3k_pkg::word_type   lo
);
   import mr3k_pkg::*;

   localparam logic [2:0] MD_IDLE = 3'd0;
   localparam logic [2:0] MD_MUL  = 3'd1;
   localparam logic [2:0] MD_MFIX = 3'd2;
   localparam logic [2:0] MD_DIV  = 3'd3;
   localparam logic [2:0] MD_DFIX = 3'd4;

   logic [2:0]  st_ff, st_in;
   word_type    a_ff, a_in, b_ff, b_in;
   logic        sgn_ff, sgn_in;
   logic [63:0] prod_ff, prod_in;
   word_type    rem_ff, rem_in, quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in;
   word_type    hi_ff, hi_in, lo_ff, lo_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   word_type    mag_a, mag_b;

   assign mag_a = (md_req.is_signed && opa[31]) ? (32'd0 - opa) : opa;
   assign mag_b = (md_req.is_signed && opb[31]) ? (32'd0 - opb) : opb;
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, b_ff};

   always_comb begin
      st_in   = st_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      sgn_in  = sgn_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      qneg_in = qneg_ff;
      rneg_in = rneg_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      done_in = 1'b0;
      unique case (st_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               sgn_in = md_req.is_signed;
               if (md_req.is_div) begin
                  b_in    = mag_b;
                  quo_in  = mag_a;
                  rem_in  = '0;
                  cnt_in  = '0;
                  qneg_in = md_req.is_signed && (opa[31] ^ opb[31]);
                  rneg_in = md_req.is_signed && opa[31];
                  st_in   = MD_DIV;
               end else begin
                  a_in  = opa;
                  b_in  = opb;
                  st_in = MD_MUL;
               end
            end
         end
         MD_MUL: begin
            prod_in = {32'd0, a_ff} * {32'd0, b_ff};
            st_in   = MD_MFIX;
         end
         MD_MFIX: begin
            // signed product from the unsigned one: subtract the cross terms
            hi_in = prod_ff[63:32]
                    - ((sgn_ff && a_ff[31]) ? b_ff : 32'd0)
                    - ((sgn_ff && b_ff[31]) ? a_ff : 32'd0);
            lo_in   = prod_ff[31:0];
            done_in = 1'b1;
            st_in   = MD_IDLE;
         end
         MD_DIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], quo_ff[31]};
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               st_in = MD_DFIX;
            end
         end
         MD_DFIX: begin
            lo_in   = qneg_ff ? (32'd0 - quo_ff) : quo_ff;
            hi_in   = rneg_ff ? (32'd0 - rem_ff) : rem_ff;
            done_in = 1'b1;
            st_in   = MD_IDLE;
         end
         default: st_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= MD_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      sgn_ff  <= sgn_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      qneg_ff <= qneg_in;
      rneg_ff <= rneg_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
   end

   assign done = done_ff;
   assign hi   = hi_ff;
   assign lo   = lo_ff;

endmodule

/* design/mips_r3000_integer_core.sv */
// Flow: an item is taken in ST_IDLE while the register file reads its operands,
// then executed and written back in ST_EXEC; MULT/MULTU and DIV/DIVU wait in ST_MD
// for the iterative multiply/divide unit and write back in ST_FIN. A new item is
// taken only after the last commits, also while the last result still waits.
// Reset: synchronous; registers read as zero, PC at the reset vector, no result
// pending. No clearing pass.
// ----------------------------------------------------------------------------
// mips_r3000_integer_core
// MIPS I integer core executing one fetched word per item around a
// synchronous register file, with exceptions, delay slot and load return.
// ----------------------------------------------------------------------------
module mips_r3000_integer_core #(
   parameter int NUM_REGS = mr3k_pkg::NumRegsDefault
) (
   input  logic       clock,
   input  logic       reset,
   mr3k_req_if.sink   req_if,
   mr3k_rsp_if.source rsp_if,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [0:0] csr_wdata
);
   import mr3k_pkg::*;

   localparam int AW = $clog2(NUM_REGS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_MD   = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   // control and item registers
   logic [1:0] state_ff, state_in;
   logic [1:0] cmd_ff, cmd_in;
   word_type   word_ff, word_in, ldata_ff, ldata_in;
   logic       irql_ff, irql_in;

   // architectural state
   word_type   pc_ff, pc_in, jt_ff, jt_in, epc_ff, epc_in, hi_ff, hi_in, lo_ff, lo_in;
   logic       jp_ff, jp_in, ids_ff, ids_in, cis_ff, cis_in, cip_ff, cip_in;
   logic [4:0] ldst_ff, ldst_in, cc_ff, cc_in;
   logic [2:0] lk_ff, lk_in;
   logic [5:0] ie_ff, ie_in;
   logic       bootv_ff, bootv_in, imask_ff, imask_in;

   // output register
   logic       rv_ff, rv_in;
   word_type   ofa_ff, ofa_in, oaddr_ff, oaddr_in, owd_ff, owd_in;
   logic [1:0] oreq_ff, oreq_in;
   logic [2:0] osize_ff, osize_in;
   logic [3:0] okind_ff, okind_in;

   logic       accept, out_free, commit, md_go, md_done;
   word_type   a, b, md_hi, md_lo;
   md_req_type md_req, md_dec;

   // register file ports
   logic [4:0] rs_rd, rt_rd;
   logic       rf_we;
   logic [4:0] rf_wa;
   word_type   rf_wd;

   // decode
   logic [5:0] op, fn;
   logic [4:0] rt, rd, sh;
   word_type   cur, seq, nxt, zimm, simm, btgt, ea, sum_ab, dif_ab, sum_ai, ldval;
   logic [3:0] kind;
   logic [4:0] code;
   logic [1:0] dreq;
   word_type   daddr, dwd, nt, wval;
   logic [2:0] dsize, dlk;
   logic       wen, nj, isj, take, chk, hi_we, lo_we;
   logic [4:0] widx;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rv_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);

   assign rs_rd = req_if.instr_word[25:21];
   assign rt_rd = req_if.instr_word[20:16];

   mr3k_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (rs_rd[AW-1:0]),
      .rd_addr_b (rt_rd[AW-1:0]),
      .wr_en     (rf_we),
      .wr_addr   (rf_wa[AW-1:0]),
      .wr_data   (rf_wd),
      .rd_data_a (a),
      .rd_data_b (b)
   );

   assign md_req.start     = (state_ff == ST_EXEC) && md_go;
   assign md_req.is_div    = md_dec.is_div;
   assign md_req.is_signed = md_dec.is_signed;

   mr3k_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .opa    (a),
      .opb    (b),
      .done   (md_done),
      .hi     (md_hi),
      .lo     (md_lo)
   );

   assign op   = word_ff[31:26];
   assign rt   = word_ff[20:16];
   assign rd   = word_ff[15:11];
   assign sh   = word_ff[10:6];
   assign fn   = word_ff[5:0];
   assign cur  = pc_ff;
   assign seq  = pc_ff + 32'd4;
   assign nxt  = jp_ff ? jt_ff : seq;
   assign zimm = {16'd0, word_ff[15:0]};
   assign simm = {{16{word_ff[15]}}, word_ff[15:0]};
   assign btgt = seq + {simm[29:0], 2'b00};
   assign sum_ab = a + b;
   assign dif_ab = a - b;
   assign sum_ai = a + simm;
   assign ea     = sum_ai;

   always_comb begin
      kind   = EXC_NONE;
      code   = CAUSE_INT;
      dreq   = MEM_NONE;
      daddr  = '0;
      dsize  = 3'd4;
      dwd    = '0;
      dlk    = LK_NONE;
      wen    = 1'b0;
      widx   = rd;
      wval   = '0;
      nj     = 1'b0;
      isj    = 1'b0;
      take   = 1'b0;
      nt     = '0;
      chk    = 1'b0;
      hi_we  = 1'b0;
      lo_we  = 1'b0;
      md_dec = '0;
      if (cur[1:0] != 2'b00) begin
         kind = EXC_ADEL;
         code = CAUSE_ADEL;
      end else if (op == OP_SPECIAL) begin
         unique case (fn)
            FN_SLL:  begin wen = 1'b1; wval = b << sh; end
            FN_SRL:  begin wen = 1'b1; wval = b >> sh; end
            FN_SRA:  begin wen = 1'b1; wval = word_type'($signed(b) >>> sh); end
            FN_SLLV: begin wen = 1'b1; wval = b << a[4:0]; end
            FN_SRLV: begin wen = 1'b1; wval = b >> a[4:0]; end
            FN_SRAV: begin wen = 1'b1; wval = word_type'($signed(b) >>> a[4:0]); end
            FN_JR:   begin isj = 1'b1; nj = 1'b1; nt = a; end
            FN_JALR: begin
               isj = 1'b1; nj = 1'b1; nt = a;
               wen = 1'b1; wval = cur + 32'd8;
            end
            FN_SYSCALL: begin kind = EXC_SYS; code = CAUSE_SYS; end
            FN_BREAK:   begin kind = EXC_BP; code = CAUSE_BP; end
            FN_MFHI: begin wen = 1'b1; wval = hi_ff; end
            FN_MTHI: hi_we = 1'b1;
            FN_MFLO: begin wen = 1'b1; wval = lo_ff; end
            FN_MTLO: lo_we = 1'b1;
            FN_MULT:  begin md_dec.start = 1'b1; md_dec.is_signed = 1'b1; end
            FN_MULTU: md_dec.start = 1'b1;
            FN_DIV: begin
               md_dec.start = 1'b1; md_dec.is_div = 1'b1; md_dec.is_signed = 1'b1;
            end
            FN_DIVU: begin md_dec.start = 1'b1; md_dec.is_div = 1'b1; end
            FN_ADD: begin
               if (~(a[31] ^ b[31]) & (a[31] ^ sum_ab[31])) begin
                  kind = EXC_OV; code = CAUSE_OV;
               end else begin
                  wen = 1'b1; wval = sum_ab;
               end
            end
            FN_ADDU: begin wen = 1'b1; wval = sum_ab; end
            FN_SUB: begin
               if ((a[31] ^ b[31]) & (a[31] ^ dif_ab[31])) begin
                  kind = EXC_OV; code = CAUSE_OV;
               end else begin
                  wen = 1'b1; wval = dif_ab;
               end
            end
            FN_SUBU: begin wen = 1'b1; wval = dif_ab; end
            FN_AND:  begin wen = 1'b1; wval = a & b; end
            FN_OR:   begin wen = 1'b1; wval = a | b; end
            FN_XOR:  begin wen = 1'b1; wval = a ^ b; end
            FN_NOR:  begin wen = 1'b1; wval = ~(a | b); end
            FN_SLT:  begin wen = 1'b1; wval = {31'd0, $signed(a) < $signed(b)}; end
            FN_SLTU: begin wen = 1'b1; wval = {31'd0, a < b}; end
            default: begin kind = EXC_RI; code = CAUSE_RI; end
         endcase
      end else begin
         unique case (op) inside
            OP_REGIMM: begin
               if (rt == RI_BLTZ || rt == RI_BGEZ || rt == RI_BLTZAL || rt == RI_BGEZAL) begin
                  isj  = 1'b1;
                  take = rt[0] ? !a[31] : a[31];
                  if (rt[4]) begin
                     wen = 1'b1; widx = 5'd31; wval = cur + 32'd8;
                  end
                  if (take) begin nj = 1'b1; nt = btgt; end
               end else begin
                  kind = EXC_RI; code = CAUSE_RI;
               end
            end
            OP_J, OP_JAL: begin
               isj = 1'b1; nj = 1'b1;
               nt  = {seq[31:28], word_ff[25:0], 2'b00};
               if (op == OP_JAL) begin
                  wen = 1'b1; widx = 5'd31; wval = cur + 32'd8;
               end
            end
            OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ: begin
               isj = 1'b1;
               unique case (op)
                  OP_BEQ:  take = (a == b);
                  OP_BNE:  take = (a != b);
                  OP_BLEZ: take = a[31] || (a == '0);
                  default: take = !a[31] && (a != '0);
               endcase
               if (take) begin nj = 1'b1; nt = btgt; end
            end
            OP_ADDI: begin
               if (~(a[31] ^ simm[31]) & (a[31] ^ sum_ai[31])) begin
                  kind = EXC_OV; code = CAUSE_OV;
               end else begin
                  wen = 1'b1; widx = rt; wval = sum_ai;
               end
            end
            OP_ADDI_WRAP: begin wen = 1'b1; widx = rt; wval = sum_ai; end
            OP_SLTI: begin
               wen = 1'b1; widx = rt; wval = {31'd0, $signed(a) < $signed(simm)};
            end
            OP_SLTI_UNS: begin wen = 1'b1; widx = rt; wval = {31'd0, a < simm}; end
            OP_ANDI:  begin wen = 1'b1; widx = rt; wval = a & zimm; end
            OP_ORI:   begin wen = 1'b1; widx = rt; wval = a | zimm; end
            OP_XORI:  begin wen = 1'b1; widx = rt; wval = a ^ zimm; end
            OP_LUI:   begin wen = 1'b1; widx = rt; wval = {word_ff[15:0], 16'd0}; end
            OP_COP0, OP_COP1, OP_COP2, OP_COP3, OP_LWC0, OP_LWC1, OP_LWC2, OP_LWC3,
            OP_SWC0, OP_SWC1, OP_SWC2, OP_SWC3: begin
               kind = EXC_CPU; code = CAUSE_CPU;
            end
            OP_LB:  begin dreq = MEM_READ; dsize = 3'd1; dlk = LK_LB;  daddr = ea; end
            OP_LBU: begin dreq = MEM_READ; dsize = 3'd1; dlk = LK_LBU; daddr = ea; end
            OP_LH: begin
               dreq = MEM_READ; dsize = 3'd2; dlk = LK_LH; daddr = ea; chk = ea[0];
            end
            OP_LHU: begin
               dreq = MEM_READ; dsize = 3'd2; dlk = LK_LHU; daddr = ea; chk = ea[0];
            end
            OP_LW: begin
               dreq = MEM_READ; dsize = 3'd4; dlk = LK_LW; daddr = ea;
               chk = (ea[1:0] != 2'b00);
            end
            OP_LWL: begin dreq = MEM_READ; dsize = 3'd4; dlk = LK_LW; daddr = ea - 32'd3; end
            OP_LWR: begin dreq = MEM_READ; dsize = 3'd4; dlk = LK_LW; daddr = ea; end
            OP_SB: begin dreq = MEM_WRITE; dsize = 3'd1; daddr = ea; dwd = {24'd0, b[7:0]}; end
            OP_SH: begin
               dreq = MEM_WRITE; dsize = 3'd2; daddr = ea; dwd = {16'd0, b[15:0]};
               chk = ea[0];
            end
            OP_SW: begin
               dreq = MEM_WRITE; dsize = 3'd4; daddr = ea; dwd = b;
               chk = (ea[1:0] != 2'b00);
            end
            OP_SWL: begin dreq = MEM_WRITE; dsize = 3'd4; daddr = ea - 32'd3; dwd = b; end
            OP_SWR: begin dreq = MEM_WRITE; dsize = 3'd4; daddr = ea; dwd = b; end
            default: begin kind = EXC_RI; code = CAUSE_RI; end
         endcase
         if (chk) begin
            if (dreq == MEM_READ) begin
               kind = EXC_ADEL; code = CAUSE_ADEL;
            end else begin
               kind = EXC_ADES; code = CAUSE_ADES;
            end
         end
      end
   end

   assign md_go  = (cmd_ff == CMD_EXEC) && (kind == EXC_NONE) && md_dec.start;
   assign commit = out_free && (((state_ff == ST_EXEC) && !md_go) || (state_ff == ST_FIN));

   always_comb begin
      unique case (lk_ff)
         LK_LB:   ldval = {{24{ldata_ff[7]}}, ldata_ff[7:0]};
         LK_LBU:  ldval = {24'd0, ldata_ff[7:0]};
         LK_LH:   ldval = {{16{ldata_ff[15]}}, ldata_ff[15:0]};
         LK_LHU:  ldval = {16'd0, ldata_ff[15:0]};
         default: ldval = ldata_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      word_in  = word_ff;
      ldata_in = ldata_ff;
      irql_in  = irql_ff;
      pc_in    = pc_ff;
      jt_in    = jt_ff;
      jp_in    = jp_ff;
      ids_in   = ids_ff;
      epc_in   = epc_ff;
      cc_in    = cc_ff;
      cis_in   = cis_ff;
      cip_in   = cip_ff;
      ie_in    = ie_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      ldst_in  = ldst_ff;
      lk_in    = lk_ff;
      bootv_in = bootv_ff;
      imask_in = imask_ff;
      rv_in    = rv_ff && !rsp_if.ready;
      ofa_in   = ofa_ff;
      oreq_in  = oreq_ff;
      oaddr_in = oaddr_ff;
      osize_in = osize_ff;
      owd_in   = owd_ff;
      okind_in = okind_ff;
      rf_we    = 1'b0;
      rf_wa    = widx;
      rf_wd    = wval;

      if (csr_we) begin
         unique case (csr_index)
            CSR_BOOT_VECTORS: bootv_in = csr_wdata[0];
            default:          imask_in = csr_wdata[0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_if.cmd;
               word_in  = req_if.instr_word;
               ldata_in = req_if.load_data;
               irql_in  = req_if.irq_line;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (md_go) begin
               state_in = ST_MD;
            end else if (commit) begin
               state_in = ST_IDLE;
            end
         end
         ST_MD: begin
            if (md_done) begin
               state_in = ST_FIN;
            end
         end
         default: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
      endcase

      if (commit) begin
         okind_in = EXC_NONE;
         oreq_in  = MEM_NONE;
         oaddr_in = '0;
         osize_in = 3'd4;
         owd_in   = '0;
         case (cmd_ff)
            CMD_LOAD: begin
               if (lk_ff != LK_NONE) begin
                  rf_we = 1'b1;
                  rf_wa = ldst_ff;
                  rf_wd = ldval;
               end
               lk_in = LK_NONE;
            end
            CMD_IRQ: begin
               cip_in = irql_ff;
               if (irql_ff && imask_ff && ie_ff[0]) begin
                  okind_in = EXC_IRQ;
                  cc_in    = CAUSE_INT;
               end
            end
            CMD_EXEC: begin
               lk_in    = LK_NONE;
               okind_in = kind;
               if (kind == EXC_NONE) begin
                  rf_we = wen;
                  if (hi_we) hi_in = a;
                  if (lo_we) lo_in = a;
                  if (state_ff == ST_FIN) begin
                     hi_in = md_hi;
                     lo_in = md_lo;
                  end
                  if (dreq == MEM_READ) begin
                     lk_in   = dlk;
                     ldst_in = rt;
                  end
                  pc_in  = nxt;
                  jp_in  = nj;
                  if (nj) jt_in = nt;
                  ids_in = isj;
                  oreq_in  = dreq;
                  oaddr_in = daddr;
                  osize_in = dsize;
                  owd_in   = dwd;
               end else begin
                  cc_in = code;
               end
            end
            default: ;
         endcase
         if (okind_in != EXC_NONE) begin
            // exception entry: push the enable stack and vector
            ie_in  = {ie_ff[3:0], 2'b00};
            epc_in = ids_ff ? (pc_ff - 32'd4) : pc_ff;
            cis_in = ids_ff;
            jp_in  = 1'b0;
            ids_in = 1'b0;
            pc_in  = bootv_ff ? VEC_BOOT : VEC_NORM;
         end else if (cmd_ff != CMD_EXEC) begin
            cc_in = cc_ff;
         end
         ofa_in = pc_in;
         rv_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= RESET_PC;
         jt_ff    <= '0;
         jp_ff    <= 1'b0;
         ids_ff   <= 1'b0;
         epc_ff   <= '0;
         cc_ff    <= CAUSE_INT;
         cis_ff   <= 1'b0;
         cip_ff   <= 1'b0;
         ie_ff    <= '0;
         hi_ff    <= '0;
         lo_ff    <= '0;
         ldst_ff  <= '0;
         lk_ff    <= LK_NONE;
         bootv_ff <= 1'b1;
         imask_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         jt_ff    <= jt_in;
         jp_ff    <= jp_in;
         ids_ff   <= ids_in;
         epc_ff   <= epc_in;
         cc_ff    <= cc_in;
         cis_ff   <= cis_in;
         cip_ff   <= cip_in;
         ie_ff    <= ie_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
         ldst_ff  <= ldst_in;
         lk_ff    <= lk_in;
         bootv_ff <= bootv_in;
         imask_ff <= imask_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      word_ff  <= word_in;
      ldata_ff <= ldata_in;
      irql_ff  <= irql_in;
      ofa_ff   <= ofa_in;
      oreq_ff  <= oreq_in;
      oaddr_ff <= oaddr_in;
      osize_ff <= osize_in;
      owd_ff   <= owd_in;
      okind_ff <= okind_in;
   end

   assign rsp_if.valid      = rv_ff;
   assign rsp_if.fetch_addr = ofa_ff;
   assign rsp_if.mem_req    = oreq_ff;
   assign rsp_if.mem_addr   = oaddr_ff;
   assign rsp_if.mem_size   = osize_ff;
   assign rsp_if.mem_wdata  = owd_ff;
   assign rsp_if.exc_kind   = okind_ff;

endmodule
